[hw/rtl/otu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otu_pkg: shared types and constants of the odometry trajectory tracker
// Widths, CORDIC constants, the arctangent table and configuration indexes.
// ----------------------------------------------------------------------------
package otu_pkg;

  // Field widths
  localparam int POS_W  = 32;  // signed Q16.16 position
  localparam int DIFF_W = 33;  // difference of two positions
  localparam int MAG_W  = 33;  // unsigned Q17.16 distance
  localparam int ANG_W  = 26;  // signed angle in 2^-16 degree
  localparam int LEN_W  = 48;  // unsigned Q32.16 path length
  localparam int CNT_W  = 16;  // waypoint count
  localparam int BRG_W  = 16;  // bearing in 1/128 degree
  localparam int THR_W  = 32;  // threshold registers

  // CORDIC datapath
  localparam int CORDIC_STEPS_DEF = 24;
  localparam int GUARD_BITS = 8;
  localparam int CORD_XW    = 44;  // x and y working width
  localparam int ITER_W     = 5;   // indexes the 32-entry arctangent table
  localparam int TAB_W      = 22;
  localparam int GAIN_W     = 20;
  localparam int MUL_LO_W   = 22;  // low slice of x for the split multiply
  localparam int PROD_W     = 64;
  localparam int MAG_SHIFT  = GUARD_BITS + 20;

  localparam logic [GAIN_W-1:0] GAIN_Q20 = 20'd636751;
  localparam logic [MAG_W-1:0]  MAX33    = {MAG_W{1'b1}};
  localparam logic signed [ANG_W-1:0] HALF_TURN_FINE = 26'sd11796480;
  localparam logic signed [BRG_W-1:0] BEARING_LIMIT  = 16'sd23040;

  localparam logic [TAB_W-1:0] ATAN_FINE [32] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
    22'd234379,  22'd117304,  22'd58666,  22'd29335,
    22'd14668,   22'd7334,    22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115,
    22'd57,      22'd29,      22'd14,     22'd7,
    22'd4,       22'd2,       22'd1,      22'd0,
    22'd0,       22'd0,       22'd0,      22'd0,
    22'd0,       22'd0,       22'd0,      22'd0
  };

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_RECORD_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_THR  = 2'd1;

  localparam logic [THR_W-1:0] RECORD_THR_RESET = 32'd3277;
  localparam logic [THR_W-1:0] NOISE_THR_RESET  = 32'd66;

  // Request to and response from the shared CORDIC unit
  typedef struct packed {
    logic                     start;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
  } cord_req_t;

  typedef struct packed {
    logic                    done;
    logic [MAG_W-1:0]        mag;
    logic signed [ANG_W-1:0] ang;
  } cord_rsp_t;

endpackage

[hw/rtl/otu_cordic.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otu_cordic: iterative vectoring CORDIC
// One rotation per cycle, then a two-slice gain multiply and the unfold step.
// ----------------------------------------------------------------------------
module otu_cordic #(
  parameter int CORDIC_STEPS = otu_pkg::CORDIC_STEPS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  otu_pkg::cord_req_t req,
  output otu_pkg::cord_rsp_t rsp
);

  localparam int XW  = otu_pkg::CORD_XW;
  localparam int ZW  = otu_pkg::ANG_W;
  localparam int IW  = otu_pkg::ITER_W;
  localparam int LW  = otu_pkg::MUL_LO_W;
  localparam int HW  = XW - LW;
  localparam int GW  = otu_pkg::GAIN_W;
  localparam int PLW = LW + GW;
  localparam int PHW = HW + GW;
  localparam int PW  = otu_pkg::PROD_W;
  localparam int DW  = otu_pkg::DIFF_W;
  localparam int MW  = otu_pkg::MAG_W;
  localparam int SH  = otu_pkg::MAG_SHIFT;

  typedef enum logic [2:0] {
    C_IDLE, C_ITER, C_MUL_LO, C_MUL_HI, C_FIN
  } cstate_t;

  cstate_t state;
  logic signed [XW-1:0] x, y;
  logic signed [ZW-1:0] z;
  logic [IW-1:0] iter;
  logic dx_neg, dy_neg;
  logic [PLW-1:0] prod_lo;
  logic [PHW-1:0] prod_hi;

  logic [DW-1:0] abs_dx, abs_dy;
  logic signed [XW-1:0] xs, ys;
  logic signed [ZW-1:0] step_ang;
  logic y_pos;
  logic [PW-1:0] prod_sum;
  logic [PW-SH-1:0] mag_full;
  logic signed [ZW-1:0] z_half, z_out;

  always_comb begin
    abs_dx   = req.dx[DW-1] ? (~req.dx + 1'b1) : req.dx;
    abs_dy   = req.dy[DW-1] ? (~req.dy + 1'b1) : req.dy;
    xs       = x >>> iter;
    ys       = y >>> iter;
    y_pos    = !y[XW-1] && (y != '0);
    step_ang = $signed({{(ZW-otu_pkg::TAB_W){1'b0}}, otu_pkg::ATAN_FINE[iter]});
    prod_sum = {{(PW-PLW){1'b0}}, prod_lo} + {prod_hi, {LW{1'b0}}}
             + (PW'(1) << (SH - 1));
    mag_full = prod_sum[PW-1:SH];
    z_half   = dx_neg ? (otu_pkg::HALF_TURN_FINE - z) : z;
    z_out    = dy_neg ? -z_half : z_half;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= C_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      case (state)
        C_IDLE: begin
          if (req.start) begin
            if (req.dx == '0 && req.dy == '0) begin
              // A zero vector has no direction: report zero length and angle.
              rsp.mag  <= '0;
              rsp.ang  <= '0;
              rsp.done <= 1'b1;
            end else begin
              x      <= $signed({{(XW-DW-otu_pkg::GUARD_BITS){1'b0}}, abs_dx,
                                 {otu_pkg::GUARD_BITS{1'b0}}});
              y      <= $signed({{(XW-DW-otu_pkg::GUARD_BITS){1'b0}}, abs_dy,
                                 {otu_pkg::GUARD_BITS{1'b0}}});
              z      <= '0;
              iter   <= '0;
              dx_neg <= req.dx[DW-1];
              dy_neg <= req.dy[DW-1];
              state  <= C_ITER;
            end
          end
        end
        C_ITER: begin
          if (y_pos) begin
            x <= x + ys;
            y <= y - xs;
            z <= z + step_ang;
          end else begin
            x <= x - ys;
            y <= y + xs;
            z <= z - step_ang;
          end
          if (iter == IW'(CORDIC_STEPS - 1)) begin
            state <= C_MUL_LO;
          end else begin
            iter <= iter + 1'b1;
          end
        end
        C_MUL_LO: begin
          prod_lo <= {{GW{1'b0}}, x[LW-1:0]} * {{LW{1'b0}}, otu_pkg::GAIN_Q20};
          state   <= C_MUL_HI;
        end
        C_MUL_HI: begin
          prod_hi <= {{GW{1'b0}}, x[XW-1:LW]} * {{HW{1'b0}}, otu_pkg::GAIN_Q20};
          state   <= C_FIN;
        end
        C_FIN: begin
          rsp.mag  <= (mag_full > {{(PW-SH-MW){1'b0}}, otu_pkg::MAX33})
                      ? otu_pkg::MAX33 : mag_full[MW-1:0];
          rsp.ang  <= z_out;
          rsp.done <= 1'b1;
          state    <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/odometry_trajectory_tracker_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odometry_trajectory_tracker_unit: path length, waypoints and bearing home
// Tracks odometry samples and reports distance and bearing back to start.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready, pos_x, pos_y) takes one odometry
//   sample per transfer. The output channel (out_valid/out_ready) returns one
//   result per sample: total path length, distance and bearing to the start
//   point, a waypoint flag and the waypoint count.
//   The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets
//   the record threshold (index 0) and the noise threshold (index 1); other
//   indexes are ignored. Write it only while no sample is in flight.
//   Each sample runs up to three vectors through one shared iterative CORDIC,
//   one rotation per clock. in_ready is high only between samples and
//   returns in the cycle the result appears, so the block takes no new
//   sample before it has finished the last one. The first sample needs no
//   waypoint distance and finishes sooner.
//   A finished result sits in the output register while the next sample is
//   taken; if the receiver still stalls when that sample finishes, the block
//   waits with the new result until the output register frees up.
//   Synchronous reset clears the tracking state, restores the threshold
//   defaults and drops any result not yet transferred.
// ----------------------------------------------------------------------------
module odometry_trajectory_tracker_unit #(
  parameter int CORDIC_STEPS = otu_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [otu_pkg::POS_W-1:0]     pos_x,
  input  logic signed [otu_pkg::POS_W-1:0]     pos_y,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [otu_pkg::LEN_W-1:0]            path_length,
  output logic [otu_pkg::MAG_W-1:0]            distance_to_start,
  output logic signed [otu_pkg::BRG_W-1:0]     home_bearing,
  output logic                                 waypoint_recorded,
  output logic [otu_pkg::CNT_W-1:0]            waypoint_count,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [otu_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [otu_pkg::THR_W-1:0]            cfg_data
);

  localparam int PW = otu_pkg::POS_W;
  localparam int LW = otu_pkg::LEN_W;
  localparam int MW = otu_pkg::MAG_W;
  localparam int ZW = otu_pkg::ANG_W;
  localparam int BW = otu_pkg::BRG_W;
  localparam int CW = otu_pkg::CNT_W;
  localparam int TW = otu_pkg::THR_W;

  // The sequencer walks through up to three CORDIC jobs of one sample. Each
  // job has a state that issues the request and a state that waits for the response.
  typedef enum logic [2:0] {
    S_IDLE, S_STEP_GO, S_STEP_WAIT, S_WP_GO, S_WP_WAIT,
    S_HOME_GO, S_HOME_WAIT, S_EMIT
  } state_t;

  state_t state;

  // Tracking state
  logic started;
  logic signed [PW-1:0] start_x, start_y;
  logic signed [PW-1:0] prev_x, prev_y;
  logic signed [PW-1:0] wp_x, wp_y;
  logic [LW-1:0] total_length;
  logic [CW-1:0] waypoints_seen;
  logic [TW-1:0] record_thr, noise_thr;

  // Current sample and its partial results
  logic signed [PW-1:0] cur_x, cur_y;
  logic record;
  logic [MW-1:0] dstart;
  logic signed [BW-1:0] bearing;

  otu_pkg::cord_req_t creq;
  otu_pkg::cord_rsp_t crsp;

  logic [LW:0] length_sum;
  logic signed [ZW:0] ang_round;
  logic signed [ZW:0] ang_fine;

  assign in_ready  = (state == S_IDLE) && !rst;
  assign cfg_ready = !rst;

  // Operand selection for the shared CORDIC: each job gets its own vector.
  always_comb begin
    creq.start = 1'b0;
    creq.dx    = '0;
    creq.dy    = '0;
    case (state)
      S_STEP_GO: begin
        creq.start = 1'b1;
        creq.dx    = {cur_x[PW-1], cur_x} - {prev_x[PW-1], prev_x};
        creq.dy    = {cur_y[PW-1], cur_y} - {prev_y[PW-1], prev_y};
      end
      S_WP_GO: begin
        creq.start = 1'b1;
        creq.dx    = {cur_x[PW-1], cur_x} - {wp_x[PW-1], wp_x};
        creq.dy    = {cur_y[PW-1], cur_y} - {wp_y[PW-1], wp_y};
      end
      S_HOME_GO: begin
        creq.start = 1'b1;
        creq.dx    = {start_x[PW-1], start_x} - {cur_x[PW-1], cur_x};
        creq.dy    = {start_y[PW-1], start_y} - {cur_y[PW-1], cur_y};
      end
      default: begin
        creq.start = 1'b0;
      end
    endcase
  end

  // Saturating path length and rounding of the fine angle to 1/128 degree.
  always_comb begin
    length_sum = {1'b0, total_length} + {{(LW+1-MW){1'b0}}, crsp.mag};
    ang_round  = {crsp.ang[ZW-1], crsp.ang} + (ZW+1)'(256);
    ang_fine   = ang_round >>> 9;
  end

  otu_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk(clk),
    .rst(rst),
    .req(creq),
    .rsp(crsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      started        <= 1'b0;
      start_x        <= '0;
      start_y        <= '0;
      prev_x         <= '0;
      prev_y         <= '0;
      wp_x           <= '0;
      wp_y           <= '0;
      total_length   <= '0;
      waypoints_seen <= '0;
      record_thr     <= otu_pkg::RECORD_THR_RESET;
      noise_thr      <= otu_pkg::NOISE_THR_RESET;
      out_valid      <= 1'b0;
    end else begin
      // A transferred result frees the output register, unless the next
      // result is loaded into it in the same cycle.
      if (out_valid && out_ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          otu_pkg::REG_RECORD_THR: record_thr <= cfg_data;
          otu_pkg::REG_NOISE_THR:  noise_thr  <= cfg_data;
          default: begin
          end
        endcase
      end

      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            cur_x <= pos_x;
            cur_y <= pos_y;
            // The first sample sets the origin and the first step point.
            if (!started) begin
              start_x <= pos_x;
              start_y <= pos_y;
              prev_x  <= pos_x;
              prev_y  <= pos_y;
            end
            state <= S_STEP_GO;
          end
        end
        S_STEP_GO:   state <= S_STEP_WAIT;
        S_STEP_WAIT: begin
          if (crsp.done) begin
            // Steps at or below the noise floor are dropped entirely.
            if (crsp.mag > {{(MW-TW){1'b0}}, noise_thr}) begin
              total_length <= length_sum[LW] ? {LW{1'b1}} : length_sum[LW-1:0];
              prev_x       <= cur_x;
              prev_y       <= cur_y;
            end
            if (started) begin
              state <= S_WP_GO;
            end else begin
              record <= 1'b1;
              state  <= S_HOME_GO;
            end
          end
        end
        S_WP_GO:   state <= S_WP_WAIT;
        S_WP_WAIT: begin
          if (crsp.done) begin
            record <= crsp.mag >= {{(MW-TW){1'b0}}, record_thr};
            state  <= S_HOME_GO;
          end
        end
        S_HOME_GO: begin
          // The waypoint moves even when the count has saturated.
          if (record) begin
            wp_x <= cur_x;
            wp_y <= cur_y;
            if (waypoints_seen != {CW{1'b1}}) begin
              waypoints_seen <= waypoints_seen + 1'b1;
            end
          end
          started <= 1'b1;
          state   <= S_HOME_WAIT;
        end
        S_HOME_WAIT: begin
          if (crsp.done) begin
            dstart <= crsp.mag;
            if (ang_fine > (ZW+1)'(otu_pkg::BEARING_LIMIT)) begin
              bearing <= otu_pkg::BEARING_LIMIT;
            end else if (ang_fine < -(ZW+1)'(otu_pkg::BEARING_LIMIT)) begin
              bearing <= -otu_pkg::BEARING_LIMIT;
            end else begin
              bearing <= ang_fine[BW-1:0];
            end
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          // Hold the finished result until the output register is free.
          if (!out_valid || out_ready) begin
            path_length       <= total_length;
            distance_to_start <= dstart;
            home_bearing      <= bearing;
            waypoint_recorded <= record;
            waypoint_count    <= waypoints_seen;
            out_valid         <= 1'b1;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/otu_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otu_checker: port-level checks for the odometry trajectory tracker
// Watches the top-level ports and is attached to every instance by bind.
// ----------------------------------------------------------------------------
module otu_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic signed [otu_pkg::POS_W-1:0] pos_x,
  input logic signed [otu_pkg::POS_W-1:0] pos_y,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [otu_pkg::LEN_W-1:0]        path_length,
  input logic [otu_pkg::MAG_W-1:0]        distance_to_start,
  input logic signed [otu_pkg::BRG_W-1:0] home_bearing,
  input logic                             waypoint_recorded,
  input logic [otu_pkg::CNT_W-1:0]        waypoint_count,
  input logic                             cfg_valid,
  input logic                             cfg_ready,
  input logic [otu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input logic [otu_pkg::THR_W-1:0]        cfg_data
);

  // Path length and waypoint count of the last result transferred.
  logic [otu_pkg::LEN_W-1:0] last_length;
  logic [otu_pkg::CNT_W-1:0] last_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_length <= '0;
      last_count  <= '0;
    end else if (out_valid && out_ready) begin
      last_length <= path_length;
      last_count  <= waypoint_count;
    end
  end

  // A stalled result keeps its path length, distance, bearing and waypoint count.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(path_length)
      && $stable(distance_to_start) && $stable(home_bearing)
      && $stable(waypoint_count))
    else $error("result changed while stalled");

  // A new result only appears while a sample is being worked on.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared with no sample in flight");

  // Path length and waypoint count never go backward between results.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> path_length >= last_length && waypoint_count >= last_count)
    else $error("path length or waypoint count decreased");

  // A recorded waypoint is always counted.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && waypoint_recorded |-> waypoint_count != '0)
    else $error("waypoint recorded with zero count");

  // The bearing stays within a half turn.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> home_bearing <= otu_pkg::BEARING_LIMIT
      && home_bearing >= -otu_pkg::BEARING_LIMIT)
    else $error("bearing out of range");

endmodule

bind odometry_trajectory_tracker_unit otu_checker u_otu_checker (.*);

[test/odometry_trajectory_tracker_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odometry_trajectory_tracker_unit_test: self-checking bench for the tracker
// Streams odometry samples through the block under several threshold settings
// and idle patterns. A scoreboard predicts path length, distance and bearing
// to the start point, and waypoint bookkeeping. It checks every result
// transfer field by field, in order.
// ----------------------------------------------------------------------------
import otu_pkg::*;

class trajectory_scoreboard;

  typedef struct {
    logic [LEN_W-1:0]        path_length;
    logic [MAG_W-1:0]        distance;
    logic signed [BRG_W-1:0] bearing;
    logic                    recorded;
    logic [CNT_W-1:0]        count;
  } track_result_t;

  // Threshold registers as the block should hold them.
  logic [THR_W-1:0] record_thr;
  logic [THR_W-1:0] noise_thr;

  // Tracking state: anchor is the start point, last is the previous point
  // that counted toward the path, mark is the latest waypoint.
  bit                have_anchor;
  longint            anchor_x, anchor_y;
  longint            last_x, last_y;
  longint            mark_x, mark_y;
  longint unsigned   odometer;
  int unsigned       marks;

  track_result_t     pending[$];
  int                failures;

  function new();
    record_thr  = RECORD_THR_RESET;
    noise_thr   = NOISE_THR_RESET;
    have_anchor = 0;
    anchor_x = 0; anchor_y = 0;
    last_x = 0;   last_y = 0;
    mark_x = 0;   mark_y = 0;
    odometer = 0;
    marks    = 0;
    failures = 0;
  endfunction

  function void set_threshold(logic [CFG_IDX_W-1:0] idx, logic [THR_W-1:0] val);
    if (idx == REG_RECORD_THR) begin
      record_thr = val;
    end else if (idx == REG_NOISE_THR) begin
      noise_thr = val;
    end
  endfunction

  // Vectoring CORDIC: magnitude in Q.16 and angle in 2^-16 degree.
  function void vector_polar(input longint dx, input longint dy,
                             output longint unsigned mag, output longint ang);
    longint          x, y, z, xs, ys;
    longint unsigned ux, m;
    if (dx == 0 && dy == 0) begin
      mag = 0;
      ang = 0;
      return;
    end
    x = (dx < 0 ? -dx : dx) * (64'sd1 <<< GUARD_BITS);
    y = (dy < 0 ? -dy : dy) * (64'sd1 <<< GUARD_BITS);
    z = 0;
    for (int i = 0; i < CORDIC_STEPS_DEF && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(ATAN_FINE[i]);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(ATAN_FINE[i]);
      end
    end
    ux  = x;
    m   = (ux * 64'(GAIN_Q20) + (64'd1 << (MAG_SHIFT - 1))) >> MAG_SHIFT;
    mag = (m > MAX33) ? 64'(MAX33) : m;
    if (dx < 0) z = longint'(HALF_TURN_FINE) - z;
    if (dy < 0) z = -z;
    ang = z;
  endfunction

  function void note_sample(logic signed [POS_W-1:0] px_in, logic signed [POS_W-1:0] py_in);
    longint          px, py, ang, brg;
    longint unsigned step, to_mark, to_anchor;
    track_result_t   res;
    px = longint'(px_in);
    py = longint'(py_in);
    if (!have_anchor) begin
      anchor_x = px; anchor_y = py;
      last_x   = px; last_y   = py;
    end

    // Steps at or below the noise floor are jitter and do not move the point.
    vector_polar(px - last_x, py - last_y, step, ang);
    if (step > longint'(noise_thr)) begin
      odometer = odometer + step;
      if (odometer > {LEN_W{1'b1}}) odometer = {LEN_W{1'b1}};
      last_x = px;
      last_y = py;
    end

    if (!have_anchor) begin
      res.recorded = 1'b1;
    end else begin
      vector_polar(px - mark_x, py - mark_y, to_mark, ang);
      res.recorded = (to_mark >= longint'(record_thr));
    end
    if (res.recorded) begin
      mark_x = px;
      mark_y = py;
      if (marks < 65535) marks++;
    end
    have_anchor = 1;

    vector_polar(anchor_x - px, anchor_y - py, to_anchor, ang);
    brg = (ang + 256) >>> 9;
    if (brg > longint'(BEARING_LIMIT)) brg = longint'(BEARING_LIMIT);
    if (brg < -longint'(BEARING_LIMIT)) brg = -longint'(BEARING_LIMIT);

    res.path_length = odometer[LEN_W-1:0];
    res.distance    = to_anchor[MAG_W-1:0];
    res.bearing     = brg[BRG_W-1:0];
    res.count       = marks[CNT_W-1:0];
    pending.insert(pending.size(), res);
  endfunction

  task report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $time, field, got, want);
    failures++;
  endtask

  task check_result(logic [LEN_W-1:0] got_len, logic [MAG_W-1:0] got_dist,
                    logic signed [BRG_W-1:0] got_brg, logic got_wp,
                    logic [CNT_W-1:0] got_cnt);
    track_result_t want;
    if (pending.size() == 0) begin
      report_mismatch("unexpected result", 64'(got_len), 64'd0);
      return;
    end
    want = pending.pop_front();
    if (got_len !== want.path_length)
      report_mismatch("path_length", 64'(got_len), 64'(want.path_length));
    if (got_dist !== want.distance)
      report_mismatch("distance_to_start", 64'(got_dist), 64'(want.distance));
    if (got_brg !== want.bearing)
      report_mismatch("home_bearing", 64'(got_brg), 64'(want.bearing));
    if (got_wp !== want.recorded)
      report_mismatch("waypoint_recorded", 64'(got_wp), 64'(want.recorded));
    if (got_cnt !== want.count)
      report_mismatch("waypoint_count", 64'(got_cnt), 64'(want.count));
  endtask

endclass

module odometry_trajectory_tracker_unit_test;

  // Indexes outside the register map; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;
  localparam logic [THR_W-1:0]        THR_MAX = {THR_W{1'b1}};

  // One sample runs three CORDIC vectors; this covers it with some margin.
  localparam int SETTLE_CYCLES = 3 * CORDIC_STEPS_DEF + 24;
  // Far beyond the slowest legal run: every sample with the longest sender
  // gap, every result with the longest receiver stall, plus all drains.
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int PHASE_SAMPLES = 85;

  logic                     clk;
  logic                     rst       = 1'b1;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  logic signed [POS_W-1:0]  pos_x     = '0;
  logic signed [POS_W-1:0]  pos_y     = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [LEN_W-1:0]         path_length;
  logic [MAG_W-1:0]         distance_to_start;
  logic signed [BRG_W-1:0]  home_bearing;
  logic                     waypoint_recorded;
  logic [CNT_W-1:0]         waypoint_count;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [THR_W-1:0]         cfg_data  = '0;

  trajectory_scoreboard sb;

  // Percent of cycles in which the sender holds back and the receiver stalls.
  int          idle_pct  = 0;
  int          stall_pct = 0;
  int          stall_run = 0;
  int unsigned cycle_count = 0;

  // Corner positions used when the random trajectory jumps to an extreme.
  logic signed [POS_W-1:0] corners [4] = '{POS_MIN, POS_MAX, 32'sd0, -32'sd1};

  odometry_trajectory_tracker_unit dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .pos_x             (pos_x),
    .pos_y             (pos_y),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .path_length       (path_length),
    .distance_to_start (distance_to_start),
    .home_bearing      (home_bearing),
    .waypoint_recorded (waypoint_recorded),
    .waypoint_count    (waypoint_count),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog. A hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side. The values read here are the ones from before the edge, so a
  // transfer is seen exactly when out_valid and out_ready were both high.
  // Stalls are drawn per cycle; a cap on back-to-back stalls keeps the
  // worst case bounded.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(path_length, distance_to_start, home_bearing,
                      waypoint_recorded, waypoint_count);
    if (stall_run >= 40 || $urandom_range(99) >= stall_pct) begin
      out_ready <= 1'b1;
      stall_run <= 0;
    end else begin
      out_ready <= 1'b0;
      stall_run <= stall_run + 1;
    end
  end

  // Presents one sample and returns at the edge where it transfers. The valid
  // stays high afterwards, so a following sample with no gap goes out
  // back to back without valid dropping in between.
  task automatic send_sample(input logic signed [POS_W-1:0] x,
                             input logic signed [POS_W-1:0] y);
    int gap;
    gap = 0;
    if (idle_pct > 0) begin
      // Mostly per-cycle idling. Now and then a long gap, so that the next
      // sample arrives at any point of the block's work on the previous one.
      if ($urandom_range(7) == 0) begin
        gap = $urandom_range(180);
      end else begin
        while (gap < 200 && $urandom_range(99) < idle_pct) gap++;
      end
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pos_x    <= x;
    pos_y    <= y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_sample(x, y);
  endtask

  // Drops the input valid and waits until every outstanding result has been
  // transferred. Then it lets the block settle. Register writes happen
  // only after this.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_threshold(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic signed [POS_W-1:0] walk_x, walk_y;
    longint                  dx, dy;
    int                      scale, pick;

    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed samples at the reset thresholds, with no idling on either side.
    // The first sample sets the start at the origin, so it must be a waypoint
    // with zero distance and a zero bearing.
    send_sample(32'sd0, 32'sd0);
    send_sample(32'sd0, 32'sd0);        // zero step, zero vectors everywhere
    send_sample(32'sd1, 32'sd0);        // jitter below the noise floor
    send_sample(32'sd0, -32'sd1);
    send_sample(32'sd66, 32'sd0);       // step right at the noise floor
    send_sample(32'sd67, 32'sd0);
    send_sample(32'sd3277, 32'sd0);     // distance right at the record threshold
    // One meter out along each axis and diagonal: bearing in every quadrant.
    send_sample(32'sd65536, 32'sd0);
    send_sample(-32'sd65536, 32'sd0);
    send_sample(32'sd0, 32'sd65536);
    send_sample(32'sd0, -32'sd65536);
    send_sample(32'sd65536, 32'sd65536);
    send_sample(-32'sd65536, 32'sd65536);
    send_sample(-32'sd65536, -32'sd65536);
    send_sample(32'sd65536, -32'sd65536);
    // Extreme positions give the widest differences the datapath must carry.
    send_sample(POS_MAX, POS_MAX);
    send_sample(POS_MIN, POS_MIN);
    send_sample(POS_MAX, POS_MIN);
    send_sample(POS_MIN, POS_MAX);
    send_sample(POS_MIN, 32'sd0);
    send_sample(32'sd0, POS_MAX);
    send_sample(-32'sd1, -32'sd1);
    send_sample(32'sd0, 32'sd0);        // back at the start point

    walk_x = 32'sd0;
    walk_y = 32'sd0;
    for (int ph = 0; ph < 8; ph++) begin
      drain_results();
      case (ph)
        0: begin
          // Zero record threshold: every sample is a waypoint. Writes to
          // indexes outside the map must not disturb the thresholds.
          write_reg(REG_RECORD_THR, '0);
          write_reg(REG_NOISE_THR, '0);
          write_reg(REG_SPARE_A, $urandom);
          write_reg(REG_SPARE_B, $urandom);
        end
        1: begin
          write_reg(REG_RECORD_THR, THR_MAX);
          write_reg(REG_NOISE_THR, THR_MAX);
        end
        2: begin
          write_reg(REG_RECORD_THR, $urandom_range(1 << 20));
          write_reg(REG_NOISE_THR, $urandom_range(4096));
        end
        3: begin
          write_reg(REG_RECORD_THR, RECORD_THR_RESET);
          write_reg(REG_NOISE_THR, NOISE_THR_RESET);
        end
        4: begin
          write_reg(REG_RECORD_THR, $urandom);
          write_reg(REG_NOISE_THR, $urandom);
        end
        5: begin
          write_reg(REG_RECORD_THR, $urandom_range(200000));
          write_reg(REG_NOISE_THR, '0);
        end
        6: begin
          write_reg(REG_RECORD_THR, THR_MAX);
          write_reg(REG_NOISE_THR, '0);
        end
        default: begin
          write_reg(REG_RECORD_THR, '0);
          write_reg(REG_NOISE_THR, $urandom_range(1 << 16));
        end
      endcase

      // Rotate through the idle patterns: none, sender idle, receiver stall,
      // both lightly.
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 83; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 83; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase

      for (int n = 0; n < PHASE_SAMPLES; n++) begin
        // Most samples follow a trajectory with steps sized around the
        // thresholds. The rest are jitter, repeats, wild jumps and corners.
        pick = $urandom_range(99);
        if (pick < 55) begin
          case ($urandom_range(4))
            0: scale = 8;
            1: scale = 128;
            2: scale = 4096;
            3: scale = 65536;
            default: scale = 1 << 20;
          endcase
          dx = longint'($urandom_range(2 * scale)) - scale;
          dy = longint'($urandom_range(2 * scale)) - scale;
          walk_x = POS_W'(walk_x + dx);
          walk_y = POS_W'(walk_y + dy);
        end else if (pick < 70) begin
          walk_x = walk_x + $signed($urandom_range(4)) - 2;
          walk_y = walk_y + $signed($urandom_range(4)) - 2;
        end else if (pick < 80) begin
          // Same point again: a zero step.
        end else if (pick < 93) begin
          walk_x = $urandom;
          walk_y = $urandom;
        end else begin
          walk_x = corners[2'($urandom_range(3))];
          walk_y = corners[2'($urandom_range(3))];
        end
        send_sample(walk_x, walk_y);

        // Occasionally the sender holds off until the block has fully drained.
        if ($urandom_range(39) == 0) drain_results();
      end
    end

    drain_results();
    if (sb.failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
